### rtl/skid_steer_mode_and_drive_mixer_core_assert.svh
// assertion macros used by the mixer sequencer
`ifndef SKID_STEER_MODE_AND_DRIVE_MIXER_CORE_ASSERT_SVH
`define SKID_STEER_MODE_AND_DRIVE_MIXER_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define SSDM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define SSDM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/ssdm_pkg.sv
// types, codes and widths shared by the mixer controller and datapath
`default_nettype none

package ssdm_pkg;

  localparam int WHEEL_W   = 30;  // signed wheel speed in 1/2000 mm/s
  localparam int MAG_W     = 29;  // wheel magnitude and divisor
  localparam int PWM_W     = 8;
  localparam int NUM_W     = MAG_W + PWM_W;
  localparam int DIV_STEPS = PWM_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);
  localparam int SUBUNITS  = 2000;

  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 32;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 16;

  localparam logic [2:0] CMD_MANUAL_VEL = 3'd0;
  localparam logic [2:0] CMD_AUTO_VEL   = 3'd1;
  localparam logic [2:0] CMD_MODE_REQ   = 3'd2;
  localparam logic [2:0] CMD_AUX_WRITE  = 3'd3;
  localparam logic [2:0] CMD_TICK       = 3'd4;

  localparam logic [2:0] MODE_STANDBY   = 3'd0;
  localparam logic [2:0] MODE_MANUAL    = 3'd1;
  localparam logic [2:0] MODE_RECORDING = 3'd2;
  localparam logic [2:0] MODE_RETURNING = 3'd3;
  localparam logic [2:0] MODE_PARKING   = 3'd4;
  localparam logic [2:0] MODE_EMERGENCY = 3'd5;

  localparam logic [1:0] REQ_TOGGLE_MANUAL = 2'd0;
  localparam logic [1:0] REQ_PARKING       = 2'd1;
  localparam logic [1:0] REQ_RECORD_RETURN = 2'd2;
  localparam logic [1:0] REQ_CANCEL        = 2'd3;

  localparam logic [CFG_ADDR_W-1:0] REG_MAX_PWM   = 4'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_TRACK     = 4'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_LIN_LIMIT = 4'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_ANG_LIMIT = 4'd3;

  localparam logic FRAME_STATUS = 1'b0;
  localparam logic FRAME_PWM    = 1'b1;

  localparam logic signed [15:0] PARK_SPEED = 16'sd50;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_STAT,
    ST_CLAMP,
    ST_WHEEL,
    ST_SUM,
    ST_DEN,
    ST_MUL,
    ST_DLOAD,
    ST_DIV,
    ST_PWM
  } ssdm_state_t;

  typedef struct packed {
    logic take;
    logic load_status;
    logic load_pwm;
    logic zero_pwm;
    logic clamp;
    logic wheel;
    logic sum;
    logic den;
    logic mul;
    logic dload;
    logic div_step;
    logic div_last;
    logic side;       // 0 left wheel, 1 right wheel
  } ssdm_cmd_t;

  typedef struct packed {
    logic mode_park;
    logic mode_mix;
  } ssdm_stat_t;

endpackage

`default_nettype wire

### rtl/skid_steer_mode_and_drive_mixer_core.sv
// top level of the skid-steer mode controller and drive mixer
`default_nettype none

//  channel | direction | beat fields
//  --------+-----------+-------------------------------------------------------
//  in_     | sink      | tuser: cmd; tdata: lin_vel, ang_vel, request_code,
//          |           |   measured_speed, aux_value
//  out_    | source    | tuser: frame_kind; tlast: last_of_run; tdata: status_mode,
//          |           |   aux_out, left_forward/magnitude, right_forward/magnitude
//  cfg_    | sink      | cfg_addr register index, cfg_data value, always ready
//
//  non-tick beats are applied as they are taken and in_tready stays high between them
//  a tick loads its status beat once the out_ slot is free, then the pwm beat: a zero frame
//    in standby or emergency, none in parking, and in a driving mode after four mixer stages, per wheel
//    a multiply, a load and 8 shared-divider steps, then the pwm load
//  in_tready is low from a tick until its pwm load (its status load in parking);
//    a stalled out_ beat only delays the next frame load; rst_n is synchronous

module skid_steer_mode_and_drive_mixer_core
  import ssdm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // [15:0] lin_vel, [31:16] ang_vel, [33:32] request_code,
  // [49:34] measured_speed, [57:50] aux_value, rest zero
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // [2:0] cmd
  input  wire logic [2:0]            in_tuser,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // [2:0] status_mode, [10:3] aux_out, [11] left_forward, [19:12] left_magnitude,
  // [20] right_forward, [28:21] right_magnitude, rest zero
  output logic [OUT_DATA_W-1:0]      out_tdata,
  // [0] frame_kind
  output logic                       out_tuser,
  output logic                       out_tlast,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  ssdm_cmd_t  cmd;
  ssdm_stat_t stat;

  // the config port is always ready; a write lands on the clock edge where cfg_valid is high
  assign cfg_ready = 1'b1;

  // sequencer: handshakes, frame order, divider step count
  ssdm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tuser   (in_tuser),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // mode state, mixer arithmetic and the output beat register
  ssdm_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .cfg_valid (cfg_valid),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

endmodule

`default_nettype wire

### rtl/ssdm_ctrl.sv
// sequencer for command beats, frame emission and the shared divider
`default_nettype none

module ssdm_ctrl
  import ssdm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  input  wire logic [2:0] in_tuser,
  output logic            in_tready,
  output logic            out_tvalid,
  input  wire logic       out_tready,
  input  wire ssdm_stat_t stat,
  output ssdm_cmd_t       cmd
);

  ssdm_state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic side_r, side_nxt;
  logic out_valid_r, out_valid_nxt;
  logic slot_free;
  logic cnt_last;

  assign slot_free = !out_valid_r || out_tready;
  assign cnt_last  = (cnt_r == CNT_W'(DIV_STEPS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      side_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      side_r      <= side_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    side_nxt  = side_r;
    cmd       = '0;
    cmd.side  = side_r;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.take = 1'b1;
          if (in_tuser == CMD_TICK) state_nxt = ST_STAT;
        end
      end
      ST_STAT: begin
        if (slot_free) begin
          cmd.load_status = 1'b1;
          cmd.zero_pwm    = !stat.mode_mix;
          if (stat.mode_park) state_nxt = ST_IDLE;
          else if (stat.mode_mix) state_nxt = ST_CLAMP;
          else state_nxt = ST_PWM;
        end
      end
      ST_CLAMP: begin
        cmd.clamp = 1'b1;
        side_nxt  = 1'b0;
        state_nxt = ST_WHEEL;
      end
      ST_WHEEL: begin
        cmd.wheel = 1'b1;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = ST_DEN;
      end
      ST_DEN: begin
        cmd.den   = 1'b1;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_DLOAD;
      end
      ST_DLOAD: begin
        cmd.dload = 1'b1;
        cnt_nxt   = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_last) begin
          cmd.div_last = 1'b1;
          if (!side_r) begin
            side_nxt  = 1'b1;
            state_nxt = ST_MUL;
          end else begin
            state_nxt = ST_PWM;
          end
        end
      end
      ST_PWM: begin
        if (slot_free) begin
          cmd.load_pwm = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.load_status || cmd.load_pwm) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  assign out_tvalid = out_valid_r;

`include "skid_steer_mode_and_drive_mixer_core_assert.svh"

  `SSDM_ASSERT_NEXT(a_tick_goes_status, in_tvalid && in_tready && in_tuser == CMD_TICK, state_r == ST_STAT, "tick beat did not start a status frame")
  `SSDM_ASSERT_NEXT(a_div_runs_full, state_r == ST_DIV && !cnt_last, state_r == ST_DIV && cnt_r == $past(cnt_r) + 1'b1, "divider left early")
  `SSDM_ASSERT_NOW(a_load_needs_slot, cmd.load_status || cmd.load_pwm, !out_valid_r || out_tready, "frame loaded over a waiting beat")
  `SSDM_ASSERT_NEXT(a_pwm_load_valid, cmd.load_pwm, out_tvalid && state_r == ST_IDLE, "pwm frame load lost")

endmodule

`default_nettype wire

### rtl/ssdm_dp.sv
// mode and target registers, config registers, mixer arithmetic and output register
`default_nettype none

module ssdm_dp
  import ssdm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire ssdm_cmd_t             cmd,
  output ssdm_stat_t                 stat,
  input  wire logic [2:0]            in_tuser,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  input  wire logic                  cfg_valid,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output logic [OUT_DATA_W-1:0]      out_tdata,
  output logic                       out_tuser,
  output logic                       out_tlast
);

  // input fields
  logic signed [15:0] lin_vel, ang_vel, meas;
  logic [1:0] req;
  logic [7:0] aux_in;

  assign lin_vel = $signed(in_tdata[15:0]);
  assign ang_vel = $signed(in_tdata[31:16]);
  assign req     = in_tdata[33:32];
  assign meas    = $signed(in_tdata[49:34]);
  assign aux_in  = in_tdata[57:50];

  // config
  logic [7:0]  max_pwm_r;
  logic [11:0] track_r;
  logic [14:0] lin_lim_r;
  logic [15:0] ang_lim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_pwm_r <= 8'd255;
      track_r   <= 12'd130;
      lin_lim_r <= 15'd880;
      ang_lim_r <= 16'd236;
    end else if (cfg_valid) begin
      unique case (cfg_addr)
        REG_MAX_PWM:   max_pwm_r <= cfg_data[7:0];
        REG_TRACK:     track_r   <= cfg_data[11:0];
        REG_LIN_LIMIT: lin_lim_r <= cfg_data[14:0];
        REG_ANG_LIMIT: ang_lim_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // vehicle state
  logic [2:0] mode_r, mode_nxt, mode_req;
  logic signed [15:0] tlin_r, tlin_nxt, tang_r, tang_nxt;
  logic [7:0] aux_r, aux_nxt;

  always_comb begin
    mode_req = mode_r;
    unique case (req)
      REQ_TOGGLE_MANUAL: begin
        if (mode_r == MODE_STANDBY) mode_req = MODE_MANUAL;
        else if (mode_r == MODE_MANUAL) mode_req = MODE_STANDBY;
      end
      REQ_PARKING: begin
        if (mode_r == MODE_MANUAL && meas < PARK_SPEED && meas > -PARK_SPEED)
          mode_req = MODE_PARKING;
      end
      REQ_RECORD_RETURN: begin
        if (mode_r == MODE_MANUAL) mode_req = MODE_RECORDING;
        else if (mode_r == MODE_RECORDING) mode_req = MODE_RETURNING;
      end
      REQ_CANCEL: begin
        if (mode_r != MODE_STANDBY && mode_r != MODE_MANUAL) mode_req = MODE_MANUAL;
      end
      default: ;
    endcase
  end

  always_comb begin
    mode_nxt = mode_r;
    tlin_nxt = tlin_r;
    tang_nxt = tang_r;
    aux_nxt  = aux_r;
    if (cmd.take) begin
      unique case (in_tuser)
        CMD_MANUAL_VEL: begin
          if (mode_r == MODE_MANUAL || mode_r == MODE_RECORDING) begin
            tlin_nxt = lin_vel;
            tang_nxt = ang_vel;
          end
        end
        CMD_AUTO_VEL: begin
          if (mode_r == MODE_RETURNING || mode_r == MODE_PARKING) begin
            tlin_nxt = lin_vel;
            tang_nxt = ang_vel;
          end
        end
        CMD_MODE_REQ: begin
          if (mode_req != mode_r) begin
            mode_nxt = mode_req;
            tlin_nxt = '0;
            tang_nxt = '0;
          end
        end
        CMD_AUX_WRITE: aux_nxt = aux_in;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_STANDBY;
      tlin_r <= '0;
      tang_r <= '0;
      aux_r  <= '0;
    end else begin
      mode_r <= mode_nxt;
      tlin_r <= tlin_nxt;
      tang_r <= tang_nxt;
      aux_r  <= aux_nxt;
    end
  end

  assign stat.mode_park = (mode_r == MODE_PARKING);
  assign stat.mode_mix  = (mode_r == MODE_MANUAL) || (mode_r == MODE_RECORDING) ||
                          (mode_r == MODE_RETURNING);

  // clamp stage
  logic signed [17:0] v18, w18, vlim18, wlim18;
  logic signed [15:0] vc_r;
  logic signed [16:0] wc_r;

  assign v18    = 18'(tlin_r);
  assign w18    = 18'(tang_r);
  assign vlim18 = $signed({3'b000, lin_lim_r});
  assign wlim18 = $signed({2'b00, ang_lim_r});

  always_ff @(posedge clk) begin
    if (cmd.clamp) begin
      if (v18 > vlim18) vc_r <= vlim18[15:0];
      else if (v18 < -vlim18) vc_r <= 16'(-vlim18);
      else vc_r <= tlin_r;
      if (w18 > wlim18) wc_r <= wlim18[16:0];
      else if (w18 < -wlim18) wc_r <= 17'(-wlim18);
      else wc_r <= 17'(tang_r);
    end
  end

  // wheel terms
  localparam logic signed [WHEEL_W-1:0] SUB_S = WHEEL_W'(SUBUNITS);
  logic signed [WHEEL_W-1:0] vterm_r, wterm_r;

  always_ff @(posedge clk) begin
    if (cmd.wheel) begin
      vterm_r <= WHEEL_W'(vc_r) * SUB_S;
      wterm_r <= WHEEL_W'(wc_r) * WHEEL_W'($signed({1'b0, track_r}));
    end
  end

  // wheel speeds, magnitudes and full scale
  logic signed [WHEEL_W-1:0] vl, vr, vl_abs, vr_abs;
  logic [MAG_W-1:0] al_r, ar_r, full_r, den_r;
  logic neg_l_r, neg_r_r, den_zero_r;

  assign vl     = vterm_r - wterm_r;
  assign vr     = vterm_r + wterm_r;
  assign vl_abs = vl[WHEEL_W-1] ? -vl : vl;
  assign vr_abs = vr[WHEEL_W-1] ? -vr : vr;

  always_ff @(posedge clk) begin
    if (cmd.sum) begin
      al_r    <= vl_abs[MAG_W-1:0];
      ar_r    <= vr_abs[MAG_W-1:0];
      neg_l_r <= vl[WHEEL_W-1];
      neg_r_r <= vr[WHEEL_W-1];
      full_r  <= MAG_W'(lin_lim_r) * MAG_W'(SUBUNITS);
    end
  end

  // divisor is the largest of full scale and both wheel magnitudes, or zero if full scale is zero
  logic [MAG_W-1:0] den_ab;
  assign den_ab = (al_r > ar_r) ? al_r : ar_r;

  always_ff @(posedge clk) begin
    if (cmd.den) begin
      den_zero_r <= (full_r == '0);
      if (full_r == '0) den_r <= '0;
      else den_r <= (den_ab > full_r) ? den_ab : full_r;
    end
  end

  // product with max pwm, then restoring division, one quotient bit a cycle
  logic [NUM_W-1:0] num_r;
  logic [MAG_W-1:0] rem_r;
  logic [PWM_W-1:0] lo_r, q_r, q_nxt;
  logic [MAG_W:0]   trial, trial_sub;
  logic             ge;

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      num_r <= NUM_W'(cmd.side ? ar_r : al_r) * NUM_W'(max_pwm_r);
    end
  end

  assign trial     = {rem_r, lo_r[PWM_W-1]};
  assign ge        = (trial >= {1'b0, den_r});
  assign trial_sub = trial - {1'b0, den_r};
  assign q_nxt     = {q_r[PWM_W-2:0], ge};

  always_ff @(posedge clk) begin
    if (cmd.dload) begin
      rem_r <= num_r[NUM_W-1:PWM_W];
      lo_r  <= num_r[PWM_W-1:0];
      q_r   <= '0;
    end else if (cmd.div_step) begin
      rem_r <= ge ? trial_sub[MAG_W-1:0] : trial[MAG_W-1:0];
      lo_r  <= {lo_r[PWM_W-2:0], 1'b0};
      q_r   <= q_nxt;
    end
  end

  // per-wheel results
  logic [PWM_W-1:0] mag_new, lmag_r, rmag_r;
  logic lfwd_r, rfwd_r, neg_sel;

  assign mag_new = den_zero_r ? '0 : q_nxt;
  assign neg_sel = cmd.side ? neg_r_r : neg_l_r;

  always_ff @(posedge clk) begin
    if (cmd.zero_pwm) begin
      lmag_r <= '0;
      rmag_r <= '0;
      lfwd_r <= 1'b1;
      rfwd_r <= 1'b1;
    end else if (cmd.div_last) begin
      if (cmd.side) begin
        rmag_r <= mag_new;
        rfwd_r <= !neg_sel || (mag_new == '0);
      end else begin
        lmag_r <= mag_new;
        lfwd_r <= !neg_sel || (mag_new == '0);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.load_status) begin
      out_tdata <= OUT_DATA_W'({aux_r, mode_r});
      out_tuser <= FRAME_STATUS;
      out_tlast <= stat.mode_park;
    end else if (cmd.load_pwm) begin
      out_tdata <= OUT_DATA_W'({rmag_r, rfwd_r, lmag_r, lfwd_r, 11'd0});
      out_tuser <= FRAME_PWM;
      out_tlast <= 1'b1;
    end
  end

endmodule

`default_nettype wire
